// ----- src/lpah_pkg.sv -----
// Shared types and constants for the linear-probe accumulating hash table.
// No dependencies; all block modules but lpah_ram import this package.
package lpah_pkg;

  localparam int SLOT_BITS  = 10;
  localparam int DEPTH      = 1 << SLOT_BITS;
  localparam int MAX_PROBES = 32;
  localparam int PROBE_W    = $clog2(MAX_PROBES + 1);
  localparam int MIN_BITS   = 2;
  localparam int HASH_ROUNDS = 4;
  localparam int MIX_SHIFT  = 2;
  localparam int ROUND_W    = $clog2(HASH_ROUNDS);
  localparam int CFG_W      = 4;
  localparam int OCC_W      = SLOT_BITS + 1;
  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 248;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] HASH_A = 32'h8c678e6b;
  localparam logic [31:0] HASH_B = 32'h9c16f733;
  localparam logic [31:0] HASH_P = 32'hFFFFFFFB;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(SLOT_BITS);

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_READ   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HIT      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_ZERO_KEY = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;

  typedef struct packed {
    mode_t                mode;
    logic                 zero_key;
    logic [63:0]          key_start;
    logic [63:0]          key_end;
    logic [63:0]          work;
    logic [SLOT_BITS-1:0] slot_select;
    logic [SLOT_BITS-1:0] home;
  } op_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key_start;
    logic [63:0] key_end;
    logic [63:0] work;
    logic [31:0] hits;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

endpackage

// ----- src/lpah_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpah_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/lpah_queue.sv -----
// Short operation queue between the hashing front end and the table engine.
// Depends on lpah_pkg.
module lpah_queue import lpah_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  op_t   push_op,
  input  logic  pop,
  output op_t   head,
  output logic  empty,
  output logic  full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head  = q_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wr_nxt = wr_r + 1'b1;
    end
    if (pop && !empty) begin
      rd_nxt = rd_r + 1'b1;
    end
    case ({push && !full, pop && !empty})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push && !full) begin
      q_r[wr_r] <= push_op;
    end
  end

endmodule

// ----- src/lpah_front.sv -----
// Front end: accepts items, checks for zero keys and computes the home slot hash.
// Depends on lpah_pkg.
module lpah_front import lpah_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [1:0]           in_tuser,
  input  logic                 init_done,
  input  logic                 q_full,
  output qctl_t                qctl,
  output op_t                  push_op
);

  typedef enum logic [8:0] {
    F_IDLE  = 9'b000000001,
    F_MUL   = 9'b000000010,
    F_ADD   = 9'b000000100,
    F_FOLD1 = 9'b000001000,
    F_FOLD2 = 9'b000010000,
    F_SUB   = 9'b000100000,
    F_RMUL  = 9'b001000000,
    F_RMIX  = 9'b010000000,
    F_PUSH  = 9'b100000000
  } fstate_t;

  fstate_t            state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [34:0]        fold_r, fold_nxt;
  logic [31:0]        h_r, h_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  logic [63:0]        key_x;
  logic [31:0]        key;
  logic [31:0]        mix;
  logic               accept;

  assign in_tready = (state_r == F_IDLE) && init_done;
  assign accept    = in_tvalid && in_tready;
  assign key_x     = op_r.key_start ^ op_r.key_end;
  assign key       = key_x[33:2];
  assign mix       = prod_r[31:0];
  assign qctl.push = (state_r == F_PUSH) && !q_full;
  assign qctl.full = q_full;

  always_comb begin
    push_op      = op_r;
    push_op.home = h_r[SLOT_BITS-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    prod_nxt  = prod_r;
    fold_nxt  = fold_r;
    h_nxt     = h_r;
    round_nxt = round_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          op_nxt.mode        = mode_t'(in_tuser);
          op_nxt.key_start   = in_tdata[63:0];
          op_nxt.key_end     = in_tdata[127:64];
          op_nxt.work        = in_tdata[191:128];
          op_nxt.slot_select = in_tdata[201:192];
          op_nxt.zero_key    = (in_tdata[63:0] == '0) || (in_tdata[127:64] == '0);
          op_nxt.home        = '0;
          round_nxt          = '0;
          if ((mode_t'(in_tuser) == MODE_ADD || mode_t'(in_tuser) == MODE_LOOKUP)
              && !op_nxt.zero_key) begin
            state_nxt = F_MUL;
          end else begin
            h_nxt     = '0;
            state_nxt = F_PUSH;
          end
        end
      end
      F_MUL: begin
        prod_nxt  = 64'(HASH_A) * 64'(key);
        state_nxt = F_ADD;
      end
      F_ADD: begin
        prod_nxt  = prod_r + 64'(HASH_B);
        state_nxt = F_FOLD1;
      end
      F_FOLD1: begin
        fold_nxt  = 35'(prod_r[63:32]) * 35'd5 + 35'(prod_r[31:0]);
        state_nxt = F_FOLD2;
      end
      F_FOLD2: begin
        fold_nxt  = 35'(fold_r[34:32]) * 35'd5 + 35'(fold_r[31:0]);
        state_nxt = F_SUB;
      end
      F_SUB: begin
        h_nxt     = (fold_r >= 35'(HASH_P)) ? 32'(fold_r - 35'(HASH_P)) : fold_r[31:0];
        state_nxt = F_RMUL;
      end
      F_RMUL: begin
        prod_nxt  = 64'(h_r) * 64'({h_r[30:0], 1'b1});
        state_nxt = F_RMIX;
      end
      F_RMIX: begin
        h_nxt     = (mix << MIX_SHIFT) | (mix >> MIX_SHIFT);
        round_nxt = round_r + 1'b1;
        state_nxt = (round_r == ROUND_W'(HASH_ROUNDS - 1)) ? F_PUSH : F_RMUL;
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r    <= op_nxt;
    prod_r  <= prod_nxt;
    fold_r  <= fold_nxt;
    h_r     <= h_nxt;
    round_r <= round_nxt;
  end

endmodule

// ----- src/lpah_back.sv -----
// Back end: probes, updates and clears the slot memory and drives the result register.
// Depends on lpah_pkg; the slot memory is an lpah_ram outside this module.
module lpah_back import lpah_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  op_t                   head,
  input  logic                  q_empty,
  output logic                  pop,
  output logic                  init_done,
  output logic                  ram_we,
  output logic [SLOT_BITS-1:0]  ram_waddr,
  output slot_t                 ram_wdata,
  output logic [SLOT_BITS-1:0]  ram_raddr,
  input  slot_t                 ram_rdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [2:0]            out_tuser
);

  typedef enum logic [6:0] {
    B_INIT = 7'b0000001,
    B_IDLE = 7'b0000010,
    B_CLR  = 7'b0000100,
    B_RD   = 7'b0001000,
    B_RCHK = 7'b0010000,
    B_PRD  = 7'b0100000,
    B_PCHK = 7'b1000000
  } bstate_t;

  bstate_t              state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [SLOT_BITS-1:0] sweep_r, sweep_nxt;
  logic [SLOT_BITS-1:0] probe_r, probe_nxt;
  logic [PROBE_W-1:0]   dist_r, dist_nxt;
  logic [OCC_W-1:0]     occ_r, occ_nxt;
  logic                 init_done_r, init_done_nxt;
  logic [CFG_W-1:0]     bits_r;
  logic                 ovalid_r, ovalid_nxt;
  logic [2:0]           ost_r, ost_nxt;
  logic [SLOT_BITS-1:0] oidx_r, oidx_nxt;
  slot_t                oent_r, oent_nxt;
  logic [CFG_W-1:0]     act_bits;
  logic [OCC_W-1:0]     cap;
  logic [SLOT_BITS-1:0] mask;
  logic [PROBE_W-1:0]   limit;
  logic                 out_free;
  logic                 key_match;
  slot_t                upd;

  always_comb begin
    act_bits = bits_r;
    if (bits_r < CFG_W'(MIN_BITS)) begin
      act_bits = CFG_W'(MIN_BITS);
    end else if (bits_r > CFG_W'(SLOT_BITS)) begin
      act_bits = CFG_W'(SLOT_BITS);
    end
  end

  assign cap       = OCC_W'(1) << act_bits;
  assign mask      = SLOT_BITS'(cap - 1'b1);
  assign limit     = (cap < OCC_W'(MAX_PROBES)) ? PROBE_W'(cap) : PROBE_W'(MAX_PROBES);
  assign out_free  = !ovalid_r || out_tready;
  assign init_done = init_done_r;
  assign key_match = (ram_rdata.key_start == op_r.key_start)
                  && (ram_rdata.key_end == op_r.key_end);
  assign ram_raddr = (state_r == B_PRD) ? probe_r : op_r.slot_select;

  assign out_tvalid = ovalid_r;
  assign out_tuser  = ost_r;
  assign out_tdata  = {3'b000, occ_r, oent_r.hits, oent_r.work,
                       oent_r.key_end, oent_r.key_start, oidx_r};

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    sweep_nxt     = sweep_r;
    probe_nxt     = probe_r;
    dist_nxt      = dist_r;
    occ_nxt       = occ_r;
    init_done_nxt = init_done_r;
    ovalid_nxt    = ovalid_r && !out_tready;
    ost_nxt       = ost_r;
    oidx_nxt      = oidx_r;
    oent_nxt      = oent_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = probe_r;
    ram_wdata     = '0;
    upd           = ram_rdata;
    unique case (state_r)
      B_INIT, B_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == SLOT_BITS'(DEPTH - 1)) begin
          state_nxt = B_IDLE;
          if (state_r == B_INIT) begin
            init_done_nxt = 1'b1;
          end else begin
            ovalid_nxt = 1'b1;
            ost_nxt    = ST_OK;
            oidx_nxt   = '0;
            oent_nxt   = '0;
          end
        end
      end
      B_IDLE: begin
        if (!q_empty && out_free) begin
          pop    = 1'b1;
          op_nxt = head;
          if (head.mode == MODE_CLEAR) begin
            occ_nxt   = '0;
            sweep_nxt = '0;
            state_nxt = B_CLR;
          end else if (head.mode == MODE_READ) begin
            if (OCC_W'(head.slot_select) >= cap) begin
              ovalid_nxt = 1'b1;
              ost_nxt    = ST_MISS;
              oidx_nxt   = '0;
              oent_nxt   = '0;
            end else begin
              state_nxt = B_RD;
            end
          end else if (head.zero_key) begin
            ovalid_nxt = 1'b1;
            ost_nxt    = ST_ZERO_KEY;
            oidx_nxt   = '0;
            oent_nxt   = '0;
          end else begin
            probe_nxt = head.home & mask;
            dist_nxt  = '0;
            state_nxt = B_PRD;
          end
        end
      end
      B_RD: state_nxt = B_RCHK;
      B_RCHK: begin
        ovalid_nxt = 1'b1;
        oidx_nxt   = op_r.slot_select;
        if (ram_rdata.valid) begin
          ost_nxt  = ST_OK;
          oent_nxt = ram_rdata;
        end else begin
          ost_nxt  = ST_MISS;
          oent_nxt = '0;
        end
        state_nxt = B_IDLE;
      end
      B_PRD: state_nxt = B_PCHK;
      B_PCHK: begin
        if (!ram_rdata.valid || key_match) begin
          state_nxt  = B_IDLE;
          ovalid_nxt = 1'b1;
          if (op_r.mode == MODE_ADD) begin
            if (!ram_rdata.valid) begin
              upd.valid     = 1'b1;
              upd.key_start = op_r.key_start;
              upd.key_end   = op_r.key_end;
              upd.work      = op_r.work;
              upd.hits      = 32'd1;
              occ_nxt       = occ_r + 1'b1;
              ost_nxt       = ST_OK;
            end else begin
              upd.work = ram_rdata.work + op_r.work;
              upd.hits = ram_rdata.hits + 1'b1;
              ost_nxt  = ST_HIT;
            end
            ram_we    = 1'b1;
            ram_wdata = upd;
            oidx_nxt  = probe_r;
            oent_nxt  = upd;
          end else if (key_match) begin
            ost_nxt  = ST_HIT;
            oidx_nxt = probe_r;
            oent_nxt = ram_rdata;
          end else begin
            ost_nxt  = ST_MISS;
            oidx_nxt = '0;
            oent_nxt = '0;
          end
        end else if (dist_r + 1'b1 == limit) begin
          state_nxt  = B_IDLE;
          ovalid_nxt = 1'b1;
          ost_nxt    = (op_r.mode == MODE_ADD) ? ST_FULL : ST_MISS;
          oidx_nxt   = '0;
          oent_nxt   = '0;
        end else begin
          probe_nxt = (probe_r + 1'b1) & mask;
          dist_nxt  = dist_r + 1'b1;
          state_nxt = B_PRD;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_INIT;
      sweep_r     <= '0;
      occ_r       <= '0;
      init_done_r <= 1'b0;
      bits_r      <= CFG_RESET;
      ovalid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      occ_r       <= occ_nxt;
      init_done_r <= init_done_nxt;
      ovalid_r    <= ovalid_nxt;
      if (cfg_we) begin
        bits_r <= cfg_wdata;
      end
    end
    op_r    <= op_nxt;
    probe_r <= probe_nxt;
    dist_r  <= dist_nxt;
    ost_r   <= ost_nxt;
    oidx_r  <= oidx_nxt;
    oent_r  <= oent_nxt;
  end

endmodule

// ----- src/linear_probe_accumulating_hash_table.sv -----
// Top level of the linear-probe accumulating hash table.
// Depends on lpah_pkg, lpah_front, lpah_queue, lpah_back and lpah_ram.
//
//   port group | dir | fields (lowest bit first)
//   in_        | in  | tuser: mode; tdata: key_start, key_end, work_amount, slot_select
//   out_       | out | tuser: status; tdata: slot_index, entry_start, entry_end,
//              |     |        entry_work, entry_count, occupied_count
//   cfg_       | in  | wdata: index_bits
//
// The front end hashes in MUL, ADD, FOLD1, FOLD2 and SUB, then RMUL and RMIX once per
// hash round, then pushes the item in PUSH, which waits while the queue is full. The
// back end pops it in IDLE, then goes through PRD and PCHK per slot probed (one slot
// memory read port), RD and RCHK for a slot read, and answers in IDLE for a zero key
// or an out-of-range read. Clear sweeps all 1024 slots, one per cycle; after reset
// the same sweep runs while in_tready stays low. A two-item queue lets the front end
// hash the next item while the back end works or its result waits to be taken.
module linear_probe_accumulating_hash_table import lpah_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // key_start, key_end, work_amount, slot_select
  input  logic [1:0]            in_tuser,   // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // slot_index, entry_start, entry_end,
                                            // entry_work, entry_count, occupied_count
  output logic [2:0]            out_tuser,  // status
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  op_t                  push_op;
  op_t                  head;
  qctl_t                qctl;
  logic                 q_empty;
  logic                 q_full;
  logic                 pop;
  logic                 init_done;
  logic                 ram_we;
  logic [SLOT_BITS-1:0] ram_waddr;
  logic [SLOT_BITS-1:0] ram_raddr;
  slot_t                ram_wdata;
  slot_t                ram_rdata;
  logic [SLOT_W-1:0]    ram_rbits;

  lpah_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .init_done (init_done),
    .q_full    (q_full),
    .qctl      (qctl),
    .push_op   (push_op)
  );

  lpah_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (qctl.push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .empty   (q_empty),
    .full    (q_full)
  );

  lpah_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .init_done  (init_done),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  assign ram_rdata = slot_t'(ram_rbits);

  lpah_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

endmodule

// ----- tb/linear_probe_accumulating_hash_table_tb.sv -----
// Testbench for the linear-probe accumulating hash table: directed and random items
// checked against a predictor of the slot table. Depends on lpah_pkg and the block's RTL.
module linear_probe_accumulating_hash_table_tb;
  import lpah_pkg::*;

  typedef struct {
    logic [2:0]       status;
    logic [9:0]       idx;
    logic [63:0]      start_a;
    logic [63:0]      end_a;
    logic [63:0]      work;
    logic [31:0]      hits;
    logic [OCC_W-1:0] occ;
  } table_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // key_start, key_end, work_amount, slot_select
  logic [1:0]            in_tuser = '0;   // mode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // slot_index, entry_start, entry_end,
                                          // entry_work, entry_count, occupied_count
  logic [2:0]            out_tuser;       // status
  logic                  cfg_we = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  linear_probe_accumulating_hash_table u_top (.*);

  always #4 clk = ~clk;

  // predicted table contents
  bit               tbl_valid [DEPTH];
  logic [63:0]      tbl_start [DEPTH];
  logic [63:0]      tbl_end [DEPTH];
  logic [63:0]      tbl_work [DEPTH];
  logic [31:0]      tbl_hits [DEPTH];
  int unsigned      tbl_occ = 0;
  logic [CFG_W-1:0] index_bits = CFG_RESET;

  table_result_t pending_results[$];
  int            errors = 0;
  int            items_sent = 0;
  int            status_seen [5];
  int            burst_left = 0;
  int            long_stall_req = 0;
  int            stall_left = 0;
  int unsigned   cyc = 0;
  logic [63:0]   pool_start [48];
  logic [63:0]   pool_end [48];

  function automatic int unsigned active_bits();
    int unsigned b;
    b = index_bits;
    if (b < MIN_BITS) b = MIN_BITS;
    if (b > SLOT_BITS) b = SLOT_BITS;
    return b;
  endfunction

  function automatic int unsigned slot_hash(logic [63:0] s, logic [63:0] e, int unsigned bits);
    logic [63:0] k;
    logic [63:0] t;
    logic [63:0] hh;
    logic [31:0] h;
    k = ((s ^ e) >> 2) & 64'hFFFF_FFFF;
    t = (64'(HASH_A) * k + 64'(HASH_B)) % 64'(HASH_P);
    h = t[31:0];
    for (int r = 0; r < HASH_ROUNDS; r++) begin
      hh = 64'(h);
      hh = hh * (2 * hh + 1);
      h = hh[31:0];
      h = (h << 2) | (h >> 2);
    end
    return h & ((1 << bits) - 1);
  endfunction

  task automatic predict_item(mode_t mode, logic [63:0] ks, logic [63:0] ke,
                              logic [63:0] wk, logic [9:0] sel);
    table_result_t r;
    int unsigned cap, lim, i, found;
    bit show;
    r = '{default: '0};
    show = 0;
    cap = 1 << active_bits();
    lim = MAX_PROBES < cap ? MAX_PROBES : cap;
    if (mode == MODE_CLEAR) begin
      foreach (tbl_valid[j]) tbl_valid[j] = 0;
      tbl_occ = 0;
      r.status = ST_OK;
    end else if (mode == MODE_READ) begin
      r.status = ST_MISS;
      if (sel < cap) begin
        r.idx = sel;
        if (tbl_valid[sel]) begin
          r.status = ST_OK;
          show = 1;
        end
      end
    end else if (ks == 0 || ke == 0) begin
      r.status = ST_ZERO_KEY;
    end else begin
      i = slot_hash(ks, ke, active_bits());
      found = 2;
      for (int d = 0; d < lim; d++) begin
        if (!tbl_valid[i]) begin
          found = 0;
          break;
        end
        if (tbl_start[i] == ks && tbl_end[i] == ke) begin
          found = 1;
          break;
        end
        i = (i + 1) & (cap - 1);
      end
      if (mode == MODE_ADD) begin
        if (found == 0) begin
          tbl_valid[i] = 1;
          tbl_start[i] = ks;
          tbl_end[i] = ke;
          tbl_work[i] = wk;
          tbl_hits[i] = 1;
          tbl_occ++;
          r.status = ST_OK;
          r.idx = 10'(i);
          show = 1;
        end else if (found == 1) begin
          tbl_work[i] += wk;
          tbl_hits[i] += 1;
          r.status = ST_HIT;
          r.idx = 10'(i);
          show = 1;
        end else begin
          r.status = ST_FULL;
        end
      end else if (found == 1) begin
        r.status = ST_HIT;
        r.idx = 10'(i);
        show = 1;
      end else begin
        r.status = ST_MISS;
      end
    end
    if (show) begin
      r.start_a = tbl_start[r.idx];
      r.end_a = tbl_end[r.idx];
      r.work = tbl_work[r.idx];
      r.hits = tbl_hits[r.idx];
    end
    r.occ = OCC_W'(tbl_occ);
    pending_results.push_back(r);
  endtask

  // check results in order
  always @(posedge clk) begin
    table_result_t x;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item, status %0d", out_tuser);
        errors++;
      end else begin
        x = pending_results.pop_front();
        if (x.status < 5) status_seen[x.status]++;
        if (out_tuser != x.status) begin
          $error("status exp %0d got %0d", x.status, out_tuser); errors++;
        end
        if (out_tdata[9:0] != x.idx) begin
          $error("slot_index exp %0d got %0d", x.idx, out_tdata[9:0]); errors++;
        end
        if (out_tdata[73:10] != x.start_a) begin
          $error("entry_start exp %h got %h", x.start_a, out_tdata[73:10]); errors++;
        end
        if (out_tdata[137:74] != x.end_a) begin
          $error("entry_end exp %h got %h", x.end_a, out_tdata[137:74]); errors++;
        end
        if (out_tdata[201:138] != x.work) begin
          $error("entry_work exp %h got %h", x.work, out_tdata[201:138]); errors++;
        end
        if (out_tdata[233:202] != x.hits) begin
          $error("entry_count exp %0d got %0d", x.hits, out_tdata[233:202]); errors++;
        end
        if (out_tdata[244:234] != x.occ) begin
          $error("occupied_count exp %0d got %0d", x.occ, out_tdata[244:234]); errors++;
        end
      end
    end
  end

  // receiver: random stalls in alternate windows, plus one long hold-off on request
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (long_stall_req != 0) begin
      stall_left <= 400;
      long_stall_req = 0;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (cyc[9]) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_item(mode_t mode, logic [63:0] ks, logic [63:0] ke,
                           logic [63:0] wk, logic [9:0] sel);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {6'b0, sel, wk, ke, ks};
    do @(posedge clk); while (!in_tready);
    predict_item(mode, ks, ke, wk, sel);
    burst_left--;
    items_sent++;
  endtask

  // hold the sender and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_index_bits(logic [CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    index_bits = v;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_basic_ops();
    logic [63:0] ones;
    ones = '1;
    send_item(MODE_ADD, 64'h0, 64'h1234, 64'h5, 10'h0);
    send_item(MODE_ADD, 64'h1234, 64'h0, 64'h5, 10'h3FF);
    send_item(MODE_LOOKUP, 64'h0, 64'h0, 64'h0, 10'h0);
    send_item(MODE_ADD, ones, ones, ones, 10'h3FF);
    send_item(MODE_ADD, ones, ones, ones, 10'h0);
    send_item(MODE_ADD, ones, ones, 64'h2, 10'h0);
    send_item(MODE_ADD, 64'h1, 64'h1, 64'h0, 10'h0);
    send_item(MODE_LOOKUP, ones, ones, 64'h0, 10'h0);
    send_item(MODE_LOOKUP, 64'h1, 64'h2, 64'h0, 10'h0);
    send_item(MODE_READ, 64'h0, 64'h0, 64'h0, 10'(slot_hash(ones, ones, SLOT_BITS)));
    send_item(MODE_READ, ones, ones, ones, 10'h3FF);
    send_item(MODE_CLEAR, ones, ones, ones, 10'h3FF);
    send_item(MODE_LOOKUP, ones, ones, 64'h0, 10'h0);
  endtask

  task automatic test_small_table();
    write_index_bits(4'd2);
    for (int k = 1; k <= 6; k++)
      send_item(MODE_ADD, 64'(k) << 8, 64'h10, 64'(k), 10'h0);
    send_item(MODE_LOOKUP, 64'h7 << 8, 64'h10, 64'h0, 10'h0);
    send_item(MODE_READ, 64'h0, 64'h0, 64'h0, 10'd3);
    send_item(MODE_READ, 64'h0, 64'h0, 64'h0, 10'd4);
    send_item(MODE_READ, 64'h0, 64'h0, 64'h0, 10'h3FF);
    write_index_bits(4'd0);
    send_item(MODE_ADD, 64'h9 << 8, 64'h10, 64'h1, 10'h0);
    send_item(MODE_ADD, 64'h2 << 8, 64'h10, 64'h1, 10'h0);
    write_index_bits(4'd15);
    send_item(MODE_ADD, 64'h2 << 8, 64'h10, 64'h1, 10'h0);
    for (int s = 0; s < 4; s++) send_item(MODE_READ, 64'h0, 64'h0, 64'h0, 10'(s));
    send_item(MODE_CLEAR, 64'h0, 64'h0, 64'h0, 10'h0);
  endtask

  task automatic test_random(int n);
    int r, p;
    logic [63:0] ks, ke;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      p = $urandom_range(0, 47);
      ks = pool_start[p];
      ke = pool_end[p];
      if ($urandom_range(0, 9) < 3) begin
        ks = rand64();
        ke = rand64();
      end
      if (r < 2) send_item(MODE_CLEAR, rand64(), rand64(), rand64(), 10'($urandom));
      else if (r < 50) send_item(MODE_ADD, ks, ke, rand64(), 10'($urandom));
      else if (r < 72) send_item(MODE_LOOKUP, ks, ke, rand64(), 10'($urandom));
      else if (r < 92) send_item(MODE_READ, rand64(), rand64(), rand64(), 10'($urandom));
      else if (r < 96) send_item(MODE_ADD, $urandom_range(0, 1) ? 64'h0 : ks,
                                 $urandom_range(0, 1) ? 64'h0 : ke, rand64(), 10'h0);
      else send_item(MODE_LOOKUP, 64'h0, rand64(), rand64(), 10'($urandom));
    end
  endtask

  task automatic test_backpressure();
    drain();
    long_stall_req = 1;
    @(posedge clk);
    burst_left = 40;
    for (int k = 0; k < 12; k++)
      send_item(MODE_ADD, pool_start[k], pool_end[k], rand64(), 10'($urandom));
    drain();
  endtask

  initial begin
    for (int k = 0; k < 48; k++) begin
      pool_start[k] = rand64() | 64'h1;
      pool_end[k] = rand64() | 64'h2;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!in_tready);
    test_basic_ops();
    test_small_table();
    write_index_bits(4'd10);
    test_random(250);
    test_backpressure();
    write_index_bits(4'd3);
    test_random(100);
    write_index_bits(4'd6);
    test_random(120);
    write_index_bits(4'd1);
    test_random(60);
    write_index_bits(4'd15);
    test_random(60);
    drain();
    $display("Sent %0d items over index widths 2..10 incl. clamped values and a long stall;",
             items_sent);
    $display("results by status ok/hit/full/zero/miss: %0d/%0d/%0d/%0d/%0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("linear_probe_accumulating_hash_table: match");
    end else begin
      $display("linear_probe_accumulating_hash_table: mismatch");
    end
    $finish;
  end

  initial begin
    #16000000;
    $display("linear_probe_accumulating_hash_table: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
src/lpah_pkg.sv
src/lpah_ram.sv
src/lpah_queue.sv
src/lpah_front.sv
src/lpah_back.sv
src/linear_probe_accumulating_hash_table.sv
tb/linear_probe_accumulating_hash_table_tb.sv
